>>> src/lcm_pkg.sv
// ----------------------------------------------------------------------------
// LCM accumulator package
// Widths, sequencer states, datapath operation codes and the status word
// shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package lcm_pkg;

    // Field and datapath widths.
    localparam int PERIOD_BITS = 16;
    localparam int RESULT_BITS = 32;
    localparam int PROD_BITS   = RESULT_BITS + PERIOD_BITS;
    localparam int SHIFT_BITS  = $clog2(PERIOD_BITS);
    localparam int COUNT_BITS  = $clog2(PERIOD_BITS);

    // Last step of the divide and multiply loops.
    localparam logic [COUNT_BITS-1:0] COUNT_LAST = COUNT_BITS'(PERIOD_BITS - 1);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWOS,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } lcm_state_t;

    // Operation applied by the datapath in the current cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TWOS,
        OP_GCD,
        OP_DIV,
        OP_MUL,
        OP_EMIT
    } lcm_op_t;

    // Status returned from the datapath to the sequencer.
    typedef struct packed {
        logic skip;       // set already saturated, no arithmetic needed
        logic odd_found;  // one gcd operand is odd
        logic equal;      // gcd operands have met
        logic last;       // final step of a divide or multiply pass
        logic out_free;   // output register can take a word this cycle
    } lcm_status_t;

endpackage

>>> src/lcm_if.sv
// ----------------------------------------------------------------------------
// LCM accumulator channels
// Valid/ready channels for the period words and the hyperperiod words.
// ----------------------------------------------------------------------------
interface lcm_in_if;
    logic                               valid;
    logic                               ready;
    logic [lcm_pkg::PERIOD_BITS-1:0]    period;
    logic                               first_of_set;

    modport source (output valid, output period, output first_of_set, input ready);
    modport sink   (input valid, input period, input first_of_set, output ready);
endinterface

interface lcm_out_if;
    logic                               valid;
    logic                               ready;
    logic [lcm_pkg::RESULT_BITS-1:0]    hyperperiod;
    logic                               overflowed;

    modport source (output valid, output hyperperiod, output overflowed, input ready);
    modport sink   (input valid, input hyperperiod, input overflowed, output ready);
endinterface

>>> src/lcm_ctrl.sv
// ----------------------------------------------------------------------------
// LCM accumulator sequencer
// Steps the shared datapath through the binary gcd, the restoring divide
// and the shift-add multiply for one period word.
// ----------------------------------------------------------------------------
module lcm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  lcm_pkg::lcm_status_t status,
    output logic                 in_ready,
    output lcm_pkg::lcm_op_t     op
);

    lcm_pkg::lcm_state_t state_reg;
    lcm_pkg::lcm_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.skip ? lcm_pkg::ST_DONE : lcm_pkg::ST_TWOS;
                end
            end
            lcm_pkg::ST_TWOS:
            begin
                if (status.odd_found)
                begin
                    state_next = lcm_pkg::ST_GCD;
                end
            end
            lcm_pkg::ST_GCD:
            begin
                if (status.equal)
                begin
                    state_next = lcm_pkg::ST_DIV;
                end
            end
            lcm_pkg::ST_DIV:
            begin
                if (status.last)
                begin
                    state_next = lcm_pkg::ST_MUL;
                end
            end
            lcm_pkg::ST_MUL:
            begin
                if (status.last)
                begin
                    state_next = lcm_pkg::ST_DONE;
                end
            end
            lcm_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = lcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and datapath operation.
    always_comb
    begin
        in_ready = 1'b0;
        op       = lcm_pkg::OP_HOLD;
        unique case (state_reg)
            lcm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                op       = in_valid ? lcm_pkg::OP_LOAD : lcm_pkg::OP_HOLD;
            end
            lcm_pkg::ST_TWOS: op = lcm_pkg::OP_TWOS;
            lcm_pkg::ST_GCD:  op = lcm_pkg::OP_GCD;
            lcm_pkg::ST_DIV:  op = lcm_pkg::OP_DIV;
            lcm_pkg::ST_MUL:  op = lcm_pkg::OP_MUL;
            lcm_pkg::ST_DONE:
            begin
                op = status.out_free ? lcm_pkg::OP_EMIT : lcm_pkg::OP_HOLD;
            end
            default:
            begin
                op = lcm_pkg::OP_HOLD;
            end
        endcase
    end

endmodule

>>> src/lcm_dp.sv
// ----------------------------------------------------------------------------
// LCM accumulator datapath
// Operand registers, the running value, one shared add/subtract unit and
// the output word register.
// ----------------------------------------------------------------------------
module lcm_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcm_pkg::lcm_op_t                  op,
    input  logic [lcm_pkg::PERIOD_BITS-1:0]   period,
    input  logic                              first_of_set,
    output lcm_pkg::lcm_status_t              status,
    lcm_out_if.source                         result
);

    localparam int PB = lcm_pkg::PERIOD_BITS;
    localparam int RB = lcm_pkg::RESULT_BITS;
    localparam int PW = lcm_pkg::PROD_BITS;

    // Architectural state and output word.
    logic [RB-1:0]                     run_reg, run_next;
    logic                              ovf_reg, ovf_next;
    logic                              out_valid_reg, out_valid_next;
    logic [RB-1:0]                     out_hyp_reg, out_hyp_next;
    logic                              out_ovf_reg, out_ovf_next;

    // Working registers.
    logic [PB-1:0]                     p_reg, p_next;
    logic [RB-1:0]                     a_reg, a_next;
    logic [RB-1:0]                     b_reg, b_next;
    logic [lcm_pkg::SHIFT_BITS-1:0]    k_reg, k_next;
    logic [PB-1:0]                     gd_reg, gd_next;
    logic [PB-1:0]                     rem_reg, rem_next;
    logic [PB-1:0]                     quo_reg, quo_next;
    logic [PW-1:0]                     acc_reg, acc_next;
    logic [lcm_pkg::COUNT_BITS-1:0]    cnt_reg, cnt_next;

    // Shared adder operands and result.
    logic [PW-1:0]                     add_x;
    logic [PW-1:0]                     add_y;
    logic                              add_sub;
    logic [PW:0]                       add_sum;
    logic                              add_carry;
    logic [PB:0]                       rem_shift;
    logic [PB-1:0]                     p_load;

    assign rem_shift = {rem_reg, quo_reg[PB-1]};
    assign p_load    = (period == '0) ? PB'(1) : period;

    // Status towards the sequencer.
    assign status.skip      = ovf_reg & ~first_of_set;
    assign status.odd_found = a_reg[0] | b_reg[0];
    assign status.equal     = (a_reg == b_reg);
    assign status.last      = (cnt_reg == lcm_pkg::COUNT_LAST);
    assign status.out_free  = ~out_valid_reg | result.ready;

    // Output channel.
    assign result.valid       = out_valid_reg;
    assign result.hyperperiod = out_hyp_reg;
    assign result.overflowed  = out_ovf_reg;

    // Operand selection for the shared add/subtract unit.
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (op)
            lcm_pkg::OP_GCD:
            begin
                add_x   = PW'(a_reg);
                add_y   = PW'(b_reg);
                add_sub = 1'b1;
            end
            lcm_pkg::OP_DIV:
            begin
                add_x   = PW'(rem_shift);
                add_y   = PW'(gd_reg);
                add_sub = 1'b1;
            end
            lcm_pkg::OP_MUL:
            begin
                add_x   = {acc_reg[PW-2:0], 1'b0};
                add_y   = quo_reg[PB-1] ? PW'(run_reg) : '0;
                add_sub = 1'b0;
            end
            default:
            begin
                add_x   = '0;
                add_y   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    // A carry out on subtraction means no borrow, so x >= y.
    assign add_sum   = {1'b0, add_x} + {1'b0, add_y ^ {PW{add_sub}}} + (PW + 1)'(add_sub);
    assign add_carry = add_sum[PW];

    // Next-state logic for all datapath registers.
    always_comb
    begin
        run_next   = run_reg;
        ovf_next   = ovf_reg;
        p_next     = p_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        gd_next    = gd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;

        // The output word clears once taken unless a new one is loaded.
        out_valid_next = out_valid_reg & ~result.ready;
        out_hyp_next   = out_hyp_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (op)
            lcm_pkg::OP_HOLD:
            begin
            end
            lcm_pkg::OP_LOAD:
            begin
                // A new set restarts the running value before this period.
                p_next = p_load;
                a_next = RB'(p_load);
                b_next = first_of_set ? RB'(1) : run_reg;
                k_next = '0;
                if (first_of_set)
                begin
                    run_next = RB'(1);
                    ovf_next = 1'b0;
                end
            end
            lcm_pkg::OP_TWOS:
            begin
                // Strip the factors of two common to both operands.
                if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
            end
            lcm_pkg::OP_GCD:
            begin
                // One binary gcd step; on a match, set up the divide.
                priority if (a_reg == b_reg)
                begin
                    gd_next  = a_reg[PB-1:0] << k_reg;
                    rem_next = '0;
                    quo_next = p_reg;
                    cnt_next = '0;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (add_carry)
                begin
                    a_next = add_sum[RB-1:0] >> 1;
                end
                else
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            lcm_pkg::OP_DIV:
            begin
                // Restoring divide, one quotient bit per cycle.
                rem_next = add_carry ? add_sum[PB-1:0] : rem_shift[PB-1:0];
                quo_next = {quo_reg[PB-2:0], add_carry};
                cnt_next = cnt_reg + 1'b1;
                if (status.last)
                begin
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            lcm_pkg::OP_MUL:
            begin
                // Shift-add multiply, quotient bits taken from the top.
                acc_next = add_sum[PW-1:0];
                quo_next = quo_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (status.last)
                begin
                    if (add_sum[PW-1:RB] != '0)
                    begin
                        run_next = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        run_next = add_sum[RB-1:0];
                    end
                end
            end
            lcm_pkg::OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_hyp_next   = run_reg;
                out_ovf_next   = ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= RB'(1);
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        gd_reg      <= gd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        out_hyp_reg <= out_hyp_next;
        out_ovf_reg <= out_ovf_next;
    end

endmodule

>>> src/running_lcm_of_periods_unit.sv
// From acceptance to a valid output word the block strips common twos, runs the binary gcd loop
// (one shift, subtract or swap per step), the restoring divide and the shift-add multiply, and
// then loads the output register. A new period word is taken only once the previous word is in
// the output register, which waits while the output register is full and its word not taken.
// A saturated set skips the arithmetic and its word goes straight to the output register.
// Reset sets the running value to 1 and clears the overflow flag and the output valid flag.
// ----------------------------------------------------------------------------
// Running LCM of periods
// Keeps the least common multiple of a set of task periods and reports the
// saturated hyperperiod with a sticky overflow flag after every period.
// ----------------------------------------------------------------------------
module running_lcm_of_periods_unit
(
    input  logic       clk,
    input  logic       rst_n,
    lcm_in_if.sink     item,
    lcm_out_if.source  result
);

    lcm_pkg::lcm_op_t     op;
    lcm_pkg::lcm_status_t status;
    logic                 in_ready;

    assign item.ready = in_ready;

    // Sequencer.
    lcm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .status   (status),
        .in_ready (in_ready),
        .op       (op)
    );

    // Datapath with the shared arithmetic unit.
    lcm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .period       (item.period),
        .first_of_set (item.first_of_set),
        .status       (status),
        .result       (result)
    );

endmodule

>>> tb/running_lcm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Running LCM checker
// Watches the period and hyperperiod channels of the LCM accumulator. It
// predicts each hyperperiod word from the accepted period words, queues it,
// and compares every accepted hyperperiod word with the oldest one queued.
// ----------------------------------------------------------------------------
module running_lcm_checker
(
    input  logic clk,
    input  logic rst_n,
    lcm_in_if    item,
    lcm_out_if   result,
    output int   fail_count,
    output int   pending
);
    localparam int PERIOD_BITS = lcm_pkg::PERIOD_BITS;
    localparam int RESULT_BITS = lcm_pkg::RESULT_BITS;
    localparam int PROD_BITS   = lcm_pkg::PROD_BITS;

    typedef struct packed {
        logic [RESULT_BITS-1:0] hyperperiod;
        logic                   overflowed;
    } lcm_word_t;

    // Running value and sticky flag of the current set, and the words still owed.
    lcm_word_t lcm_state;
    lcm_word_t lcm_expect_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Prints one line for a failed check and counts it.
    task automatic report_mismatch(input string what);
        $display("[%0t] running_lcm_checker: %s", $realtime, what);
        fail_count++;
    endtask

    // Greatest common divisor by repeated remainders.
    function automatic logic [RESULT_BITS-1:0] euclid(input logic [RESULT_BITS-1:0] a,
                                                      input logic [RESULT_BITS-1:0] b);
        logic [RESULT_BITS-1:0] rem;
        while (b != '0)
        begin
            rem = a % b;
            a   = b;
            b   = rem;
        end
        return a;
    endfunction

    // Applies one period word to the running value and gives the new state,
    // which is also the word the block must report for it.
    function automatic lcm_word_t advance_lcm(input lcm_word_t cur,
                                              input logic [PERIOD_BITS-1:0] period,
                                              input logic first);
        lcm_word_t              nxt;
        logic [RESULT_BITS-1:0] p;
        logic [RESULT_BITS-1:0] r;
        logic [RESULT_BITS-1:0] g;
        logic [RESULT_BITS-1:0] q;
        logic [PROD_BITS-1:0]   prod;
        nxt = cur;
        if (first)
        begin
            nxt.hyperperiod = RESULT_BITS'(1);
            nxt.overflowed  = 1'b0;
        end
        // A zero period counts as one and leaves the value alone.
        p = (period == '0) ? RESULT_BITS'(1) : RESULT_BITS'(period);
        if (!nxt.overflowed)
        begin
            r    = (nxt.hyperperiod == '0) ? RESULT_BITS'(1) : nxt.hyperperiod;
            g    = euclid(p, r);
            q    = p / g;
            prod = PROD_BITS'(r) * PROD_BITS'(q);
            if (prod[PROD_BITS-1:RESULT_BITS] != '0)
            begin
                nxt.hyperperiod = '1;
                nxt.overflowed  = 1'b1;
            end
            else
            begin
                nxt.hyperperiod = prod[RESULT_BITS-1:0];
            end
        end
        else
        begin
            // A saturated set holds at the maximum until the next set starts.
            nxt.hyperperiod = '1;
        end
        return nxt;
    endfunction

    // Results are checked before the new period is queued, since a word that
    // leaves the block at an edge always belongs to an earlier period.
    always @(posedge clk or negedge rst_n)
    begin
        lcm_word_t got;
        lcm_word_t want;
        if (!rst_n)
        begin
            lcm_state.hyperperiod = RESULT_BITS'(1);
            lcm_state.overflowed  = 1'b0;
            lcm_expect_q.delete();
            pending <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.hyperperiod = result.hyperperiod;
                got.overflowed  = result.overflowed;
                if (lcm_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("hyperperiod word %0d/%0b with none pending",
                                              got.hyperperiod, got.overflowed));
                end
                else
                begin
                    want = lcm_expect_q.pop_front();
                    if (got.hyperperiod !== want.hyperperiod)
                        report_mismatch($sformatf("hyperperiod %0d, expected %0d",
                                                  got.hyperperiod, want.hyperperiod));
                    if (got.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed %b, expected %b",
                                                  got.overflowed, want.overflowed));
                end
            end
            if (item.valid && item.ready)
            begin
                lcm_state = advance_lcm(lcm_state, item.period, item.first_of_set);
                lcm_expect_q.push_back(lcm_state);
            end
            pending <= lcm_expect_q.size();
        end
    end

endmodule

>>> tb/tb_running_lcm_of_periods_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Running LCM of periods testbench
// Sends directed and random sets of task periods into the LCM accumulator,
// with random gaps on the period side and random stalls on the hyperperiod
// side. The checker beside the block predicts and compares every word; this
// module makes the stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb_running_lcm_of_periods_unit;

    localparam int PERIOD_BITS  = lcm_pkg::PERIOD_BITS;
    localparam int RANDOM_WORDS = 950;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   no_gaps;

    lcm_in_if  item_ch();
    lcm_out_if result_ch();

    running_lcm_of_periods_unit i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    running_lcm_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // Random period with a bias towards small and smooth values, so that sets
    // grow over several words before they saturate.
    function automatic logic [PERIOD_BITS-1:0] pick_period();
        int unsigned r;
        int unsigned prod;
        int unsigned primes[6];
        r      = $urandom_range(0, 99);
        primes = '{2, 3, 5, 7, 11, 13};
        if (r < 35)
            return PERIOD_BITS'($urandom_range(1, 30));
        if (r < 55)
            return PERIOD_BITS'($urandom_range(1, 1000));
        if (r < 70)
            return PERIOD_BITS'($urandom_range(1, 65535));
        if (r < 80)
            return PERIOD_BITS'(1) << $urandom_range(0, PERIOD_BITS - 1);
        if (r < 92)
        begin
            prod = 1;
            repeat ($urandom_range(1, 4))
                prod = prod * primes[$urandom_range(0, 5)];
            return PERIOD_BITS'(prod);
        end
        if (r < 97)
            return PERIOD_BITS'($urandom_range(60000, 65535));
        return '0;
    endfunction

    // Offers one period word and returns at the edge that accepts it.
    task automatic send_period(input logic [PERIOD_BITS-1:0] period, input logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.period       <= period;
        item_ch.first_of_set <= first;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Hyperperiod side: random stalls between stretches of readiness.
    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_running_lcm_of_periods_unit: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int sent;
        int set_left;
        logic first;
        rst_n                <= 1'b0;
        idle_cycles          <= 0;
        no_gaps              = 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.period       <= '0;
        item_ch.first_of_set <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Words before any set start run on from the reset value of one.
        send_period(16'd1, 1'b0);
        send_period(16'hFFFF, 1'b0);
        send_period(16'd0, 1'b0);
        // Zero period opening a set.
        send_period(16'd0, 1'b1);
        send_period(16'h5555, 1'b0);
        send_period(16'hAAAA, 1'b0);
        // Largest product that still fits, then overflow and a saturated set.
        send_period(16'd65535, 1'b1);
        send_period(16'd65534, 1'b0);
        send_period(16'd65533, 1'b0);
        send_period(16'd2, 1'b0);
        send_period(16'd0, 1'b0);
        // A new set clears the sticky flag.
        send_period(16'd2, 1'b1);
        send_period(16'd12, 1'b1);
        send_period(16'd18, 1'b0);
        send_period(16'd36, 1'b0);
        send_period(16'd1, 1'b0);
        // Even operands through the shared twos.
        send_period(16'd32768, 1'b1);
        send_period(16'd16384, 1'b0);
        send_period(16'd8, 1'b0);
        send_period(16'd65521, 1'b0);
        // Large primes overflow within three words.
        send_period(16'd65521, 1'b1);
        send_period(16'd65519, 1'b0);
        send_period(16'd65497, 1'b0);
        // Overflow straight into a fresh set.
        send_period(16'd7, 1'b1);

        // Random sets of random length, with now and then a stray set start.
        sent     = 0;
        set_left = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent % 150 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (set_left == 0)
            begin
                set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                       : $urandom_range(1, 12);
                first    = ($urandom_range(0, 19) != 0);
            end
            else
            begin
                first = ($urandom_range(0, 19) == 0);
            end
            send_period(pick_period(), first);
            set_left--;
            sent++;
        end
        item_ch.valid <= 1'b0;
        no_gaps = 1'b0;

        // Let the checker count the last word before waiting for the queue to empty.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_running_lcm_of_periods_unit: PASS");
        else
            $display("tb_running_lcm_of_periods_unit: FAIL");
        $finish;
    end

endmodule
